// File: design/qpip_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the quad point-in-polygon ray cast core
package qpip_pkg;

	localparam int COORD_W   = 20;
	localparam int CELL_W    = 10;
	localparam int COST_W    = 5;
	localparam int COUNT_W   = 3;
	localparam int SIDES     = 4;
	localparam int COEF_W    = COORD_W + 1;
	localparam int CPROD_W   = 2 * COORD_W;
	localparam int CFG_IDX_W = 3;

	typedef logic [CFG_IDX_W-1:0]      cfg_idx_t;
	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [COEF_W-1:0]  coef_t;
	typedef logic signed [CPROD_W-1:0] cprod_t;
	typedef logic [CELL_W-1:0]         cell_t;
	typedef logic [COST_W-1:0]         cost_t;
	typedef logic [COUNT_W-1:0]        count_t;

	// configuration register map
	localparam cfg_idx_t REG_VERTEX0_X = 3'd0;
	localparam cfg_idx_t REG_VERTEX0_Y = 3'd1;
	localparam cfg_idx_t REG_VERTEX1_X = 3'd2;
	localparam cfg_idx_t REG_VERTEX1_Y = 3'd3;
	localparam cfg_idx_t REG_VERTEX2_X = 3'd4;
	localparam cfg_idx_t REG_VERTEX2_Y = 3'd5;
	localparam cfg_idx_t REG_VERTEX3_X = 3'd6;
	localparam cfg_idx_t REG_VERTEX3_Y = 3'd7;

	// sign of a line evaluation
	typedef struct packed {
		logic neg;
		logic zero;
	} sign_t;

	// per-stage load enables from the pipeline control
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} stage_en_t;

endpackage

// File: design/quad_point_in_polygon_ray_cast_core.sv
`timescale 1ns / 1ps
// top level of the quad point-in-polygon ray cast core
//
// Tests one grid cell per transaction against a four-sided polygon whose vertices sit in
// eight configuration registers (signed Q12.8, index 0..7 = vertex0_x, vertex0_y, ...).
// Each side's line is evaluated at the ray origin and the cell point, and the ray line at
// the four vertices; a side counts as crossed unless one pair lies strictly on one side, so
// a zero evaluation counts as touching. An odd crossing count marks the cell inside, and an
// inside cell with a cost in 1..MAX_COST_LEVEL+1 gets its class id. The core takes one cell
// every clock while in_stall is low, and each cell passes in turn through the input register,
// the product stage, the sign stage and the result register. Each stage
// moves on whenever the one after it is empty or moving, so bubbles close up while the output
// is stalled. Vertex writes take effect for any cell accepted after the write; write them
// only while no transaction is in flight.
module quad_point_in_polygon_ray_cast_core #(
	parameter int GRID_SIZE      = 1024,
	parameter int MAX_COST_LEVEL = 20,
	parameter int FRAC_BITS      = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  qpip_pkg::cfg_idx_t      cfg_index,
	input  qpip_pkg::coord_t        cfg_data,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  qpip_pkg::cell_t         cell_x,
	input  qpip_pkg::cell_t         cell_y,
	input  qpip_pkg::coord_t        ray_start_x,
	input  qpip_pkg::coord_t        ray_start_y,
	input  qpip_pkg::cost_t         ground_cost,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic                    inside_res,
	output qpip_pkg::count_t        crossing_count,
	output qpip_pkg::cost_t         class_id,
	output logic                    cost_invalid
);

	localparam int SIDES = qpip_pkg::SIDES;

	qpip_pkg::stage_en_t en;
	logic                v1_s1;
	logic                v2_s2;
	logic                v3_s3;
	logic                v4_s4;

	assign cfg_ready = 1'b1;

	// a stage loads when it is empty or its contents move on
	assign en.s4    = !v4_s4 || !out_stall;
	assign en.s3    = !v3_s3 || en.s4;
	assign en.s2    = !v2_s2 || en.s3;
	assign en.s1    = !v1_s1 || en.s2;
	assign in_stall = !en.s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			v4_s4 <= 1'b0;
		end else begin
			if (en.s1) v1_s1 <= in_valid;
			if (en.s2) v2_s2 <= v1_s1;
			if (en.s3) v3_s3 <= v2_s2;
			if (en.s4) v4_s4 <= v3_s3;
		end
	end

	assign out_valid = v4_s4;

	qpip_pkg::coord_t vx [SIDES];
	qpip_pkg::coord_t vy [SIDES];
	qpip_pkg::coef_t  side_a [SIDES];
	qpip_pkg::coef_t  side_b [SIDES];
	qpip_pkg::cprod_t cp_fwd [SIDES];
	qpip_pkg::cprod_t cp_bwd [SIDES];

	qpip_side_coef u_side_coef (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.vx        (vx),
		.vy        (vy),
		.side_a    (side_a),
		.side_b    (side_b),
		.cp_fwd    (cp_fwd),
		.cp_bwd    (cp_bwd)
	);

	qpip_pkg::sign_t org_sign_s3 [SIDES];
	qpip_pkg::sign_t pnt_sign_s3 [SIDES];
	qpip_pkg::sign_t vtx_sign_s3 [SIDES];
	logic            on_grid_s3;
	qpip_pkg::cost_t cost_s3;

	qpip_eval #(
		.GRID_SIZE (GRID_SIZE),
		.FRAC_BITS (FRAC_BITS)
	) u_eval (
		.clk         (clk),
		.en          (en),
		.cell_x      (cell_x),
		.cell_y      (cell_y),
		.ray_start_x (ray_start_x),
		.ray_start_y (ray_start_y),
		.ground_cost (ground_cost),
		.vx          (vx),
		.vy          (vy),
		.side_a      (side_a),
		.side_b      (side_b),
		.cp_fwd      (cp_fwd),
		.cp_bwd      (cp_bwd),
		.org_sign_s3 (org_sign_s3),
		.pnt_sign_s3 (pnt_sign_s3),
		.vtx_sign_s3 (vtx_sign_s3),
		.on_grid_s3  (on_grid_s3),
		.cost_s3     (cost_s3)
	);

	qpip_classify #(
		.MAX_COST_LEVEL (MAX_COST_LEVEL)
	) u_classify (
		.clk         (clk),
		.en_s4       (en.s4),
		.org_sign_s3 (org_sign_s3),
		.pnt_sign_s3 (pnt_sign_s3),
		.vtx_sign_s3 (vtx_sign_s3),
		.on_grid_s3  (on_grid_s3),
		.cost_s3     (cost_s3),
		.inside_s4   (inside_res),
		.count_s4    (crossing_count),
		.class_s4    (class_id),
		.cost_bad_s4 (cost_invalid)
	);

endmodule

// File: design/qpip_side_coef.sv
`timescale 1ns / 1ps
// vertex registers and the line coefficients of the four polygon sides
module qpip_side_coef (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  qpip_pkg::cfg_idx_t  cfg_index,
	input  qpip_pkg::coord_t    cfg_data,
	output qpip_pkg::coord_t    vx [qpip_pkg::SIDES],
	output qpip_pkg::coord_t    vy [qpip_pkg::SIDES],
	output qpip_pkg::coef_t     side_a [qpip_pkg::SIDES],
	output qpip_pkg::coef_t     side_b [qpip_pkg::SIDES],
	output qpip_pkg::cprod_t    cp_fwd [qpip_pkg::SIDES],
	output qpip_pkg::cprod_t    cp_bwd [qpip_pkg::SIDES]
);

	localparam int SIDES   = qpip_pkg::SIDES;
	localparam int COEF_W  = qpip_pkg::COEF_W;
	localparam int CPROD_W = qpip_pkg::CPROD_W;

	qpip_pkg::coord_t vx_q [SIDES];
	qpip_pkg::coord_t vy_q [SIDES];
	qpip_pkg::cprod_t cp_fwd_q [SIDES];
	qpip_pkg::cprod_t cp_bwd_q [SIDES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < SIDES; k++) begin
				vx_q[k] <= '0;
				vy_q[k] <= '0;
			end
		end else if (cfg_we) begin
			case (cfg_index)
				qpip_pkg::REG_VERTEX0_X: vx_q[0] <= cfg_data;
				qpip_pkg::REG_VERTEX0_Y: vy_q[0] <= cfg_data;
				qpip_pkg::REG_VERTEX1_X: vx_q[1] <= cfg_data;
				qpip_pkg::REG_VERTEX1_Y: vy_q[1] <= cfg_data;
				qpip_pkg::REG_VERTEX2_X: vx_q[2] <= cfg_data;
				qpip_pkg::REG_VERTEX2_Y: vy_q[2] <= cfg_data;
				qpip_pkg::REG_VERTEX3_X: vx_q[3] <= cfg_data;
				qpip_pkg::REG_VERTEX3_Y: vy_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// side k runs from vertex k to vertex k+1: a = y2-y1, b = x1-x2, c = x2*y1 - x1*y2
	always_comb begin
		for (int k = 0; k < SIDES; k++) begin
			side_a[k] = COEF_W'(vy_q[(k + 1) % SIDES]) - COEF_W'(vy_q[k]);
			side_b[k] = COEF_W'(vx_q[k]) - COEF_W'(vx_q[(k + 1) % SIDES]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < SIDES; k++) begin
				cp_fwd_q[k] <= '0;
				cp_bwd_q[k] <= '0;
			end
		end else begin
			for (int k = 0; k < SIDES; k++) begin
				cp_fwd_q[k] <= CPROD_W'(vx_q[(k + 1) % SIDES]) * CPROD_W'(vy_q[k]);
				cp_bwd_q[k] <= CPROD_W'(vx_q[k]) * CPROD_W'(vy_q[(k + 1) % SIDES]);
			end
		end
	end

	always_comb begin
		for (int k = 0; k < SIDES; k++) begin
			vx[k]     = vx_q[k];
			vy[k]     = vy_q[k];
			cp_fwd[k] = cp_fwd_q[k];
			cp_bwd[k] = cp_bwd_q[k];
		end
	end

endmodule

// File: design/qpip_eval.sv
`timescale 1ns / 1ps
// input register, product stage and sign stage of the line evaluations
module qpip_eval #(
	parameter int GRID_SIZE = 1024,
	parameter int FRAC_BITS = 8
) (
	input  logic                 clk,
	input  qpip_pkg::stage_en_t  en,
	input  qpip_pkg::cell_t      cell_x,
	input  qpip_pkg::cell_t      cell_y,
	input  qpip_pkg::coord_t     ray_start_x,
	input  qpip_pkg::coord_t     ray_start_y,
	input  qpip_pkg::cost_t      ground_cost,
	input  qpip_pkg::coord_t     vx [qpip_pkg::SIDES],
	input  qpip_pkg::coord_t     vy [qpip_pkg::SIDES],
	input  qpip_pkg::coef_t      side_a [qpip_pkg::SIDES],
	input  qpip_pkg::coef_t      side_b [qpip_pkg::SIDES],
	input  qpip_pkg::cprod_t     cp_fwd [qpip_pkg::SIDES],
	input  qpip_pkg::cprod_t     cp_bwd [qpip_pkg::SIDES],
	output qpip_pkg::sign_t      org_sign_s3 [qpip_pkg::SIDES],
	output qpip_pkg::sign_t      pnt_sign_s3 [qpip_pkg::SIDES],
	output qpip_pkg::sign_t      vtx_sign_s3 [qpip_pkg::SIDES],
	output logic                 on_grid_s3,
	output qpip_pkg::cost_t      cost_s3
);

	localparam int SIDES      = qpip_pkg::SIDES;
	localparam int COORD_W    = qpip_pkg::COORD_W;
	localparam int COEF_W     = qpip_pkg::COEF_W;
	localparam int CELL_W     = qpip_pkg::CELL_W;
	localparam int PX_W       = CELL_W + FRAC_BITS;
	localparam int PXS_W      = PX_W + 1;
	localparam int RW         = ((PXS_W > COORD_W) ? PXS_W : COORD_W) + 1;
	localparam int PW         = RW + COEF_W;
	localparam int DW         = PW + 3;
	localparam int GRID_CMP_W = CELL_W + 3;
	localparam logic [GRID_CMP_W-1:0] GRID_LIM = GRID_CMP_W'(GRID_SIZE);

	typedef logic signed [PXS_W-1:0] pt_t;
	typedef logic signed [RW-1:0]    ray_t;
	typedef logic signed [PW-1:0]    prod_t;
	typedef logic signed [DW-1:0]    sum_t;

	// cell point and ray line terms ahead of the input register
	logic [PX_W-1:0] px_raw;
	logic [PX_W-1:0] py_raw;
	pt_t             px_in;
	pt_t             py_in;
	ray_t            ray_a_in;
	ray_t            ray_b_in;
	logic            on_grid_in;

	assign px_raw     = PX_W'(cell_x) << FRAC_BITS;
	assign py_raw     = PX_W'(cell_y) << FRAC_BITS;
	assign px_in      = $signed({1'b0, px_raw});
	assign py_in      = $signed({1'b0, py_raw});
	assign ray_a_in   = RW'(py_in) - RW'(ray_start_y);
	assign ray_b_in   = RW'(ray_start_x) - RW'(px_in);
	assign on_grid_in = ({3'b000, cell_x} < GRID_LIM) && ({3'b000, cell_y} < GRID_LIM);

	pt_t              px_s1;
	pt_t              py_s1;
	qpip_pkg::coord_t ox_s1;
	qpip_pkg::coord_t oy_s1;
	ray_t             ray_a_s1;
	ray_t             ray_b_s1;
	logic             on_grid_s1;
	qpip_pkg::cost_t  cost_s1;

	always_ff @(posedge clk) begin
		if (en.s1) begin
			px_s1      <= px_in;
			py_s1      <= py_in;
			ox_s1      <= ray_start_x;
			oy_s1      <= ray_start_y;
			ray_a_s1   <= ray_a_in;
			ray_b_s1   <= ray_b_in;
			on_grid_s1 <= on_grid_in;
			cost_s1    <= ground_cost;
		end
	end

	// products: sides at ray origin and cell point, ray line at each vertex
	prod_t           so_a_s2 [SIDES];
	prod_t           so_b_s2 [SIDES];
	prod_t           sp_a_s2 [SIDES];
	prod_t           sp_b_s2 [SIDES];
	prod_t           rv_a_s2 [SIDES];
	prod_t           rv_b_s2 [SIDES];
	prod_t           rc_f_s2;
	prod_t           rc_b_s2;
	logic            on_grid_s2;
	qpip_pkg::cost_t cost_s2;

	always_ff @(posedge clk) begin
		if (en.s2) begin
			for (int k = 0; k < SIDES; k++) begin
				so_a_s2[k] <= PW'(side_a[k]) * PW'(ox_s1);
				so_b_s2[k] <= PW'(side_b[k]) * PW'(oy_s1);
				sp_a_s2[k] <= PW'(side_a[k]) * PW'(px_s1);
				sp_b_s2[k] <= PW'(side_b[k]) * PW'(py_s1);
				rv_a_s2[k] <= PW'(ray_a_s1) * PW'(vx[k]);
				rv_b_s2[k] <= PW'(ray_b_s1) * PW'(vy[k]);
			end
			rc_f_s2    <= PW'(px_s1) * PW'(oy_s1);
			rc_b_s2    <= PW'(ox_s1) * PW'(py_s1);
			on_grid_s2 <= on_grid_s1;
			cost_s2    <= cost_s1;
		end
	end

	sum_t            side_c [SIDES];
	sum_t            d_org [SIDES];
	sum_t            d_pnt [SIDES];
	sum_t            d_vtx [SIDES];
	sum_t            ray_c;
	qpip_pkg::sign_t org_sign [SIDES];
	qpip_pkg::sign_t pnt_sign [SIDES];
	qpip_pkg::sign_t vtx_sign [SIDES];

	always_comb begin
		ray_c = DW'(rc_f_s2) - DW'(rc_b_s2);
		for (int k = 0; k < SIDES; k++) begin
			side_c[k] = DW'(cp_fwd[k]) - DW'(cp_bwd[k]);
			d_org[k]  = DW'(so_a_s2[k]) + DW'(so_b_s2[k]) + side_c[k];
			d_pnt[k]  = DW'(sp_a_s2[k]) + DW'(sp_b_s2[k]) + side_c[k];
			d_vtx[k]  = DW'(rv_a_s2[k]) + DW'(rv_b_s2[k]) + ray_c;
			org_sign[k].neg  = d_org[k][DW-1];
			org_sign[k].zero = (d_org[k] == '0);
			pnt_sign[k].neg  = d_pnt[k][DW-1];
			pnt_sign[k].zero = (d_pnt[k] == '0);
			vtx_sign[k].neg  = d_vtx[k][DW-1];
			vtx_sign[k].zero = (d_vtx[k] == '0);
		end
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			for (int k = 0; k < SIDES; k++) begin
				org_sign_s3[k] <= org_sign[k];
				pnt_sign_s3[k] <= pnt_sign[k];
				vtx_sign_s3[k] <= vtx_sign[k];
			end
			on_grid_s3 <= on_grid_s2;
			cost_s3    <= cost_s2;
		end
	end

endmodule

// File: design/qpip_classify.sv
`timescale 1ns / 1ps
// crossing count, inside decision, class lookup and result register
module qpip_classify #(
	parameter int MAX_COST_LEVEL = 20
) (
	input  logic                clk,
	input  logic                en_s4,
	input  qpip_pkg::sign_t     org_sign_s3 [qpip_pkg::SIDES],
	input  qpip_pkg::sign_t     pnt_sign_s3 [qpip_pkg::SIDES],
	input  qpip_pkg::sign_t     vtx_sign_s3 [qpip_pkg::SIDES],
	input  logic                on_grid_s3,
	input  qpip_pkg::cost_t     cost_s3,
	output logic                inside_s4,
	output qpip_pkg::count_t    count_s4,
	output qpip_pkg::cost_t     class_s4,
	output logic                cost_bad_s4
);

	localparam int SIDES   = qpip_pkg::SIDES;
	localparam int COST_W  = qpip_pkg::COST_W;
	localparam int COUNT_W = qpip_pkg::COUNT_W;
	localparam int CW1     = COST_W + 1;
	localparam logic [CW1-1:0] COST_MAX = CW1'(MAX_COST_LEVEL);
	localparam logic [CW1-1:0] COST_TOP = CW1'(MAX_COST_LEVEL + 1);
	localparam qpip_pkg::cost_t TOP_CLASS = COST_W'(1);

	// both points strictly on one side of a line
	function automatic logic strict_same(qpip_pkg::sign_t a, qpip_pkg::sign_t b);
		return !a.zero && !b.zero && (a.neg == b.neg);
	endfunction

	logic [SIDES-1:0]  crossed;
	qpip_pkg::count_t  count;
	logic              in_poly;
	logic              cost_ok;
	qpip_pkg::cost_t   cls;

	always_comb begin
		count = '0;
		for (int k = 0; k < SIDES; k++) begin
			crossed[k] = !strict_same(org_sign_s3[k], pnt_sign_s3[k]) &&
			             !strict_same(vtx_sign_s3[k], vtx_sign_s3[(k + 1) % SIDES]);
			count = count + COUNT_W'(crossed[k]);
		end
		if (!on_grid_s3) begin
			count = '0;
		end
		in_poly = count[0];
		cost_ok = (cost_s3 != '0) && ({1'b0, cost_s3} <= COST_TOP);
		cls     = '0;
		if (in_poly && cost_ok) begin
			cls = ({1'b0, cost_s3} <= COST_MAX) ? cost_s3 + COST_W'(1) : TOP_CLASS;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			inside_s4   <= in_poly;
			count_s4    <= count;
			class_s4    <= cls;
			cost_bad_s4 <= !cost_ok;
		end
	end

endmodule
